>>> rtl/ssba_pkg.sv
package ssba_pkg;

    // Bin store geometry
    localparam int BINS      = 2048;
    localparam int BIN_W     = $clog2(BINS);
    localparam int BIN_END_W = BIN_W + 1;

    // Field widths
    localparam int ACT_W  = 2;
    localparam int TIME_W = 32;
    localparam int POS_W  = 7;
    localparam int MS_W   = 16;
    localparam int CNT_W  = 16;
    localparam int SUM_W  = 40;
    localparam int SPD_W  = 17;
    localparam int LVL_W  = 16;

    // Divider widths, used by the front's and the back's own dividers: 56-bit dividend, 32-bit divisor
    localparam int DIVN_W = SUM_W + LVL_W;
    localparam int DIVD_W = 32;
    localparam int DIVC_W = $clog2(DIVN_W);
    localparam int BQ_W   = TIME_W + BIN_W;

    // Stream widths
    localparam int IN_BITS  = ACT_W + TIME_W + POS_W + BIN_W;
    localparam int IN_DW    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DW   = LVL_W + CNT_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DW     = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_DURATION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED      = 1'b1;
    localparam logic [TIME_W-1:0] TD_RESET = 32'd60000;
    localparam logic [MS_W-1:0]   MS_RESET = 16'd2000;

    // Input actions
    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    // Command queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        CMD_CREDIT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [BIN_W-1:0]       first;
        logic [BIN_END_W-1:0]   stop;
        logic [SPD_W-1:0]       speed;
        logic                   sat;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic             sat;
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sum;
    } entry_t;

endpackage

>>> rtl/ssba_div.sv
// Restoring divider, one quotient bit per cycle
module ssba_div
    import ssba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVN_W-1:0] dividend,
    input  logic [DIVD_W-1:0] divisor,
    output logic              done,
    output logic [DIVN_W-1:0] quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIVC_W-1:0] cnt_reg;
    logic [DIVN_W-1:0] quo_reg;
    logic [DIVD_W-1:0] rem_reg;
    logic [DIVD_W-1:0] dsr_reg;

    logic [DIVD_W:0]   rem_sh;
    logic [DIVD_W:0]   rem_diff;
    logic              ge;

    // one shift-subtract step
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DIVN_W-1]};
        rem_diff = rem_sh - {1'b0, dsr_reg};
        ge       = (rem_sh >= {1'b0, dsr_reg});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIVC_W'(DIVN_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVN_W-2:0], ge};
            rem_reg <= ge ? rem_diff[DIVD_W-1:0] : rem_sh[DIVD_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/ssba_fifo.sv
// Short command queue between front and back
module ssba_fifo
    import ssba_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    pop_cmd,
    output q_stat_t stat
);

    cmd_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wptr_reg;
    logic [Q_PTR_W-1:0] rptr_reg;
    logic [Q_PTR_W:0]   fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= push_cmd;
    end

    assign pop_cmd    = slot_reg[rptr_reg];
    assign stat.full  = (fill_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign stat.empty = (fill_reg == '0);

endmodule

>>> rtl/ssba_front.sv
// Front: takes beats, forms strokes, works out speed and bin span
module ssba_front
    import ssba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ACT_W-1:0]  action,
    input  logic [TIME_W-1:0] time_ms,
    input  logic [POS_W-1:0]  position,
    input  logic [BIN_W-1:0]  bin_index,
    input  logic [TIME_W-1:0] total_duration,
    output logic              push,
    output cmd_t              push_cmd,
    input  q_stat_t           q_stat
);

    typedef enum logic [7:0] {
        F_IDLE    = 8'b0000_0001,
        F_SPD_GO  = 8'b0000_0010,
        F_SPD_WT  = 8'b0000_0100,
        F_B0_GO   = 8'b0000_1000,
        F_B0_WT   = 8'b0001_0000,
        F_B1_GO   = 8'b0010_0000,
        F_B1_WT   = 8'b0100_0000,
        F_PUSH    = 8'b1000_0000
    } fstate_t;

    fstate_t            state_reg, state_next;
    logic               have_last_reg;
    logic [TIME_W-1:0]  last_time_reg;
    logic [POS_W-1:0]   last_pos_reg;
    logic [TIME_W-1:0]  prev_time_reg;
    logic [TIME_W-1:0]  cur_time_reg;
    logic [TIME_W-1:0]  dt_reg;
    logic [POS_W-1:0]   dp_reg;
    logic [BQ_W-1:0]    b0_reg;
    cmd_t               cmd_reg;

    logic               accept;
    logic               div_start;
    logic               div_done;
    logic [DIVN_W-1:0]  div_q;
    logic [DIVN_W-1:0]  div_n;
    logic [DIVD_W-1:0]  div_d;
    logic [TIME_W-1:0]  dur_eff;
    logic [BQ_W-1:0]    b1;
    logic               b0_in, b1_in;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == F_IDLE);
    assign dur_eff  = (total_duration == '0) ? TIME_W'(1) : total_duration;

    // divider operand select
    always_comb
    begin
        div_start = 1'b0;
        div_n     = '0;
        div_d     = dur_eff;
        case (state_reg)
            F_SPD_GO:
            begin
                div_start = 1'b1;
                div_n     = DIVN_W'(dp_reg) * DIVN_W'(1000);
                div_d     = dt_reg;
            end
            F_B0_GO:
            begin
                div_start = 1'b1;
                div_n     = DIVN_W'({prev_time_reg, {BIN_W{1'b0}}});
            end
            F_B1_GO:
            begin
                div_start = 1'b1;
                div_n     = DIVN_W'({cur_time_reg, {BIN_W{1'b0}}});
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    ssba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    assign b1    = div_q[BQ_W-1:0];
    assign b0_in = (b0_reg[BQ_W-1:BIN_W] == '0);
    assign b1_in = (b1[BQ_W-1:BIN_W] == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ACT_ADD:
                        begin
                            if (have_last_reg && time_ms >= last_time_reg)
                                state_next = (time_ms == last_time_reg) ? F_B0_GO : F_SPD_GO;
                        end
                        ACT_READ:  state_next = F_PUSH;
                        ACT_CLEAR: state_next = F_PUSH;
                        default:   state_next = F_IDLE;
                    endcase
                end
            end
            F_SPD_GO: state_next = F_SPD_WT;
            F_SPD_WT: if (div_done) state_next = F_B0_GO;
            F_B0_GO:  state_next = F_B0_WT;
            F_B0_WT:  if (div_done) state_next = F_B1_GO;
            F_B1_GO:  state_next = F_B1_WT;
            F_B1_WT:
            begin
                if (div_done)
                begin
                    if (b0_reg == b1)
                        state_next = b0_in ? F_PUSH : F_IDLE;
                    else
                        state_next = (b0_in && b1_in) ? F_PUSH : F_IDLE;
                end
            end
            F_PUSH:   if (!q_stat.full) state_next = F_IDLE;
            default:  state_next = F_IDLE;
        endcase
    end

    // control and previous point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            have_last_reg <= 1'b0;
            last_time_reg <= '0;
            last_pos_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && action == ACT_ADD)
            begin
                have_last_reg <= 1'b1;
                last_time_reg <= time_ms;
                last_pos_reg  <= position;
            end
            else if (accept && action == ACT_CLEAR)
            begin
                have_last_reg <= 1'b0;
                last_time_reg <= '0;
                last_pos_reg  <= '0;
            end
        end
    end

    // stroke datapath and command build
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_time_reg <= last_time_reg;
            cur_time_reg  <= time_ms;
            dt_reg        <= time_ms - last_time_reg;
            dp_reg        <= (position > last_pos_reg) ? position - last_pos_reg
                                                       : last_pos_reg - position;
            cmd_reg.first <= bin_index;
            cmd_reg.stop  <= '0;
            cmd_reg.speed <= '0;
            cmd_reg.sat   <= (time_ms == last_time_reg);
            case (action)
                ACT_READ:  cmd_reg.kind <= CMD_READ;
                ACT_CLEAR: cmd_reg.kind <= CMD_CLEAR;
                default:   cmd_reg.kind <= CMD_CREDIT;
            endcase
        end
        if (state_reg == F_SPD_WT && div_done)
            cmd_reg.speed <= div_q[SPD_W-1:0];
        if (state_reg == F_B0_WT && div_done)
            b0_reg <= div_q[BQ_W-1:0];
        if (state_reg == F_B1_WT && div_done)
        begin
            cmd_reg.first <= b0_reg[BIN_W-1:0];
            if (b0_reg == b1)
                cmd_reg.stop <= BIN_END_W'(b0_reg[BIN_W-1:0]) + 1'b1;
            else
                cmd_reg.stop <= BIN_END_W'(b1[BIN_W-1:0]);
        end
    end

    assign push     = (state_reg == F_PUSH) && !q_stat.full;
    assign push_cmd = cmd_reg;

endmodule

>>> rtl/ssba_back.sv
// Back: bin store, crediting sweep, clearing sweep and bin read-out
module ssba_back
    import ssba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    input  q_stat_t           q_stat,
    output logic              pop,
    input  logic [MS_W-1:0]   max_speed,
    output logic              clearing,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [LVL_W-1:0]  bin_level,
    output logic [CNT_W-1:0]  bin_samples
);

    typedef enum logic [8:0] {
        B_CLEAR  = 9'b0_0000_0001,
        B_IDLE   = 9'b0_0000_0010,
        B_CR_RD  = 9'b0_0000_0100,
        B_CR_WR  = 9'b0_0000_1000,
        B_RD_RD  = 9'b0_0001_0000,
        B_RD_DAT = 9'b0_0010_0000,
        B_RD_GO  = 9'b0_0100_0000,
        B_RD_WT  = 9'b0_1000_0000,
        B_RD_OUT = 9'b1_0000_0000
    } bstate_t;

    bstate_t               state_reg, state_next;
    logic [BIN_W-1:0]      cur_reg;
    logic [BIN_END_W-1:0]  stop_reg;
    logic [SPD_W-1:0]      speed_reg;
    logic                  sat_reg;
    logic [DIVN_W-1:0]     num_reg;
    logic [DIVD_W-1:0]     den_reg;
    logic [LVL_W-1:0]      lvl_reg;
    logic [CNT_W-1:0]      smp_reg;
    logic                  out_valid_reg;
    logic [LVL_W-1:0]      out_lvl_reg;
    logic [CNT_W-1:0]      out_smp_reg;

    entry_t                mem [BINS];
    entry_t                rdata_reg;
    entry_t                wdata;
    logic                  we;

    logic [SUM_W:0]        sum_add;
    logic [MS_W-1:0]       ms_eff;
    logic                  last_bin;
    logic                  out_load;
    logic                  div_done;
    logic [DIVN_W-1:0]     div_q;

    assign ms_eff   = (max_speed == '0) ? MS_W'(1) : max_speed;
    assign sum_add  = {1'b0, rdata_reg.sum} + (SUM_W+1)'(speed_reg);
    assign last_bin = ((BIN_END_W'(cur_reg) + 1'b1) == stop_reg);
    assign out_load = (state_reg == B_RD_OUT) && (!out_valid_reg || out_ready);
    assign pop      = (state_reg == B_IDLE) && !q_stat.empty;
    assign clearing = (state_reg == B_CLEAR);

    // bin store write data
    always_comb
    begin
        we    = 1'b0;
        wdata = '0;
        case (state_reg)
            B_CLEAR:
            begin
                we = 1'b1;
            end
            B_CR_WR:
            begin
                we        = 1'b1;
                wdata     = rdata_reg;
                wdata.cnt = (rdata_reg.cnt == '1) ? rdata_reg.cnt : rdata_reg.cnt + 1'b1;
                if (sat_reg)
                    wdata.sat = 1'b1;
                else
                    wdata.sum = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // bin store
    always_ff @(posedge clk)
    begin
        if (we)
            mem[cur_reg] <= wdata;
        rdata_reg <= mem[cur_reg];
    end

    ssba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == B_RD_GO),
        .dividend (num_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR:  if (cur_reg == BIN_W'(BINS - 1)) state_next = B_IDLE;
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    case (cmd.kind)
                        CMD_CREDIT: state_next = B_CR_RD;
                        CMD_READ:   state_next = B_RD_RD;
                        CMD_CLEAR:  state_next = B_CLEAR;
                        default:    state_next = B_IDLE;
                    endcase
                end
            end
            B_CR_RD:  state_next = B_CR_WR;
            B_CR_WR:  state_next = last_bin ? B_IDLE : B_CR_RD;
            B_RD_RD:  state_next = B_RD_DAT;
            B_RD_DAT:
            begin
                if (rdata_reg.sat || rdata_reg.cnt == '0)
                    state_next = B_RD_OUT;
                else
                    state_next = B_RD_GO;
            end
            B_RD_GO:  state_next = B_RD_WT;
            B_RD_WT:  if (div_done) state_next = B_RD_OUT;
            B_RD_OUT: if (out_load) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                B_CLEAR:  cur_reg <= cur_reg + 1'b1;
                B_IDLE:   cur_reg <= (!q_stat.empty && cmd.kind != CMD_CLEAR) ? cmd.first : '0;
                B_CR_WR:  cur_reg <= cur_reg + 1'b1;
                default:  cur_reg <= cur_reg;
            endcase
        end
    end

    // command and read-out datapath
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            stop_reg  <= cmd.stop;
            speed_reg <= cmd.speed;
            sat_reg   <= cmd.sat;
        end
        if (state_reg == B_RD_DAT)
        begin
            smp_reg <= rdata_reg.cnt;
            lvl_reg <= rdata_reg.sat ? '1 : '0;
            // sum * 65535 without a multiplier
            num_reg <= {rdata_reg.sum, {LVL_W{1'b0}}} - DIVN_W'(rdata_reg.sum);
            den_reg <= rdata_reg.cnt * ms_eff;
        end
        if (state_reg == B_RD_WT && div_done)
            lvl_reg <= (div_q[DIVN_W-1:LVL_W] != '0) ? '1 : div_q[LVL_W-1:0];
        if (out_load)
        begin
            out_lvl_reg <= lvl_reg;
            out_smp_reg <= smp_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign bin_level   = out_lvl_reg;
    assign bin_samples = out_smp_reg;

endmodule

>>> rtl/stroke_speed_binned_average_core.sv
// Stroke speed heatmap accumulator. Each add-point beat (action 0) pairs with
// the previous point; the front runs up to three serial divisions (speed,
// start bin, end bin), and the back then credits each bin over the stroke's
// span with a read and a write. A bin read (action 1) works out the level
// in the back with the back's own divider. A clear (action 2) sweeps the
// 2048-entry bin memory at one entry a cycle; the same sweep runs after
// reset, and no input beat is taken while it runs. A four-deep command
// queue lets the front take the next beat while the back is still
// crediting, and the result register holds one finished beat while the
// back moves on.
module stroke_speed_binned_average_core
    import ssba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DW-1:0]     cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DW-1:0]      s_axis_tdata,   // action, time_ms, position, bin_index
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DW-1:0]     m_axis_tdata    // bin_level, bin_samples
);

    logic [TIME_W-1:0] td_reg;
    logic [MS_W-1:0]   ms_reg;
    logic              front_ready;
    logic              clearing;
    logic              push, pop;
    cmd_t              push_cmd, pop_cmd;
    q_stat_t           q_stat;
    logic [LVL_W-1:0]  bin_level;
    logic [CNT_W-1:0]  bin_samples;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            td_reg <= TD_RESET;
            ms_reg <= MS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TOTAL_DURATION: td_reg <= cfg_data[TIME_W-1:0];
                CFG_MAX_SPEED:      ms_reg <= cfg_data[MS_W-1:0];
                default:            td_reg <= td_reg;
            endcase
        end
    end

    assign s_axis_tready = front_ready && !clearing;

    ssba_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid && !clearing),
        .in_ready       (front_ready),
        .action         (s_axis_tdata[ACT_W-1:0]),
        .time_ms        (s_axis_tdata[ACT_W+TIME_W-1:ACT_W]),
        .position       (s_axis_tdata[ACT_W+TIME_W+POS_W-1:ACT_W+TIME_W]),
        .bin_index      (s_axis_tdata[IN_BITS-1:ACT_W+TIME_W+POS_W]),
        .total_duration (td_reg),
        .push           (push),
        .push_cmd       (push_cmd),
        .q_stat         (q_stat)
    );

    ssba_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .stat     (q_stat)
    );

    ssba_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (pop_cmd),
        .q_stat      (q_stat),
        .pop         (pop),
        .max_speed   (ms_reg),
        .clearing    (clearing),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .bin_level   (bin_level),
        .bin_samples (bin_samples)
    );

    assign m_axis_tdata = {bin_samples, bin_level};

`ifndef ASSERT_OFF
    // queue never written when full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("command queue overflow");

    // queue never read when empty
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("command queue underflow");

    // no beat taken during a clearing sweep
    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !(s_axis_tvalid && s_axis_tready))
        else $error("beat taken during clear");
`endif

endmodule
